[rtl/iom_pkg.sv]
// Package: shared types, codes and sizes of the interval overlap matcher.
`default_nettype none
package iom_pkg;

	localparam int IDX_W      = 6;
	localparam int CNT_W      = 7;
	localparam int MAX_ENTRIES = 64;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 3;

	// Request modes
	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_QUERY = 2'd1;
	localparam logic [1:0] MODE_DUMP  = 2'd2;
	localparam logic [1:0] MODE_CLEAR = 2'd3;

	// Result kinds
	localparam logic [1:0] KIND_MATCH = 2'd0;
	localparam logic [1:0] KIND_TOTAL = 2'd1;
	localparam logic [1:0] KIND_NONE  = 2'd2;
	localparam logic [1:0] KIND_FULL  = 2'd3;

	// Strand modes
	localparam logic [2:0] SM_IGNORE   = 3'd0;
	localparam logic [2:0] SM_SAME     = 3'd1;
	localparam logic [2:0] SM_OPPOSITE = 3'd2;
	localparam logic [2:0] SM_FLAG     = 3'd3;
	localparam logic [2:0] SM_SPLIT    = 3'd4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STRAND_MODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EMIT_UNFOUND = 1'd1;

	localparam logic [15:0] MAX16 = 16'hFFFF;
	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  chrom_id;
		logic [31:0] start_pos;
		logic [31:0] end_pos;
		logic        strand;
		logic [31:0] weight;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  entry_index;
		logic [1:0]  overlap_class;
		logic        antisense;
		logic        split_group;
		logic [15:0] found_count;
		logic [47:0] sense_total;
		logic [47:0] antisense_total;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  chrom;
		logic [31:0] start_pos;
		logic [31:0] end_pos;
		logic        strand;
		logic [15:0] cnt;
		logic [47:0] psum;
		logic [47:0] ssum;
	} entry_t;

	// Control from the sequencer to the cell row
	typedef struct packed {
		logic             shift;
		logic             load;
		logic [IDX_W-1:0] load_idx;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

endpackage
`default_nettype wire

[rtl/interval_overlap_matcher_top.sv]
// Top level: configuration registers, ring of entry cells and the sequencer.
//
// Requests arrive on req_valid/req_ready with a req_t payload: load an entry,
// query an interval, dump totals, or clear the table. Results leave on
// rsp_valid/rsp_ready as rsp_t; the final result of a request has last set.
// Configuration is to be written through cfg_we/cfg_index/cfg_wdata while
// idle; the block itself does not enforce this. A load or clear gives no
// result, and the next request can be taken in the cycle after it. A load
// into a full table goes through the flush state, which puts its full-table
// result in the output register, and then back to idle for the next request.
// A query or dump rotates the ring of ENTRIES cells once, one cell per cycle
// while the receiver does not stall. Each hit is held in a holding register
// so the last flag can be set, then moved to the output register; after the
// last cell the flush state moves out the held hit, or a none result, with
// last set, and the sequencer returns to idle.
// When the receiver stalls, the ring stops turning and the result waits.
// Reset empties the table, sets strand mode to ignore and enables
// reporting of unfound entries in a dump.
`default_nettype none
module interval_overlap_matcher_top #(
	parameter int ENTRIES = iom_pkg::MAX_ENTRIES
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             req_valid,
	output logic                            req_ready,
	input  iom_pkg::req_t                   req_data,
	output logic                            rsp_valid,
	input  wire                             rsp_ready,
	output iom_pkg::rsp_t                   rsp_data,
	input  wire                             cfg_we,
	input  wire [iom_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [iom_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import iom_pkg::*;

	logic [2:0] strand_mode_q;
	logic       emit_unfound_q;
	entry_t     cell_q [ENTRIES];
	entry_t     tail_in, load_data;
	cell_ctl_t  ctl;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strand_mode_q  <= SM_IGNORE;
			emit_unfound_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STRAND_MODE:  strand_mode_q  <= cfg_wdata;
				REG_EMIT_UNFOUND: emit_unfound_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Ring of cells: each takes from its upper neighbor, the last from the updated head
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		iom_cell u_cell (
			.clk       (clk),
			.shift     (ctl.shift),
			.load      (ctl.load && (ctl.load_idx == IDX_W'(i))),
			.load_data (load_data),
			.shift_in  ((i == ENTRIES - 1) ? tail_in : cell_q[(i + 1) % ENTRIES]),
			.q         (cell_q[i])
		);
	end

	iom_ctrl #(
		.ENTRIES(ENTRIES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req_data     (req_data),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp_data     (rsp_data),
		.strand_mode  (strand_mode_q),
		.emit_unfound (emit_unfound_q),
		.head         (cell_q[0]),
		.tail_in      (tail_in),
		.load_data    (load_data),
		.ctl          (ctl)
	);

endmodule
`default_nettype wire

[rtl/iom_cell.sv]
// One cell of the entry ring: holds one stored interval and its totals.
`default_nettype none
module iom_cell (
	input  wire              clk,
	input  wire              shift,
	input  wire              load,
	input  iom_pkg::entry_t  load_data,
	input  iom_pkg::entry_t  shift_in,
	output iom_pkg::entry_t  q
);
	import iom_pkg::*;

	entry_t entry_q;

	// Shift from the neighbor, or take a freshly loaded entry
	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= shift_in;
		end else if (load) begin
			entry_q <= load_data;
		end
	end

	assign q = entry_q;

endmodule
`default_nettype wire

[rtl/iom_ctrl.sv]
// Sequencer: takes requests, inspects the ring head, updates totals, emits results.
`default_nettype none
module iom_ctrl #(
	parameter int ENTRIES = iom_pkg::MAX_ENTRIES
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_ready,
	input  iom_pkg::req_t      req_data,
	output logic               rsp_valid,
	input  wire                rsp_ready,
	output iom_pkg::rsp_t      rsp_data,
	input  wire [2:0]          strand_mode,
	input  wire                emit_unfound,
	input  iom_pkg::entry_t    head,
	output iom_pkg::entry_t    tail_in,
	output iom_pkg::entry_t    load_data,
	output iom_pkg::cell_ctl_t ctl
);
	import iom_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

	state_t state_q, state_n;
	logic [CNT_W-1:0] used_q;
	logic [IDX_W-1:0] k_q;
	req_t  qry_q;
	logic  full_q;
	logic  hold_v_q;
	rsp_t  hold_q;
	logic  rsp_valid_q;
	rsp_t  rsp_q;

	logic   accept, can_push, push, step;
	rsp_t   push_data, hit_rsp;
	logic   hit;
	logic [2:0] sm;
	logic   differ, sc, ec, relevant, overlap;
	logic [1:0] cls;
	logic [48:0] sum_w;
	logic [47:0] add_src, add_res;
	entry_t upd;

	assign accept   = req_valid && req_ready;
	assign can_push = !rsp_valid_q || rsp_ready;

	// Head entry examination
	always_comb begin
		sm = (strand_mode > SM_SPLIT) ? SM_IGNORE : strand_mode;
		differ  = head.strand != qry_q.strand;
		overlap = !(head.end_pos < qry_q.start_pos || head.start_pos > qry_q.end_pos);
		sc = qry_q.start_pos >= head.start_pos;
		ec = qry_q.end_pos <= head.end_pos;
		cls = (sc && ec) ? 2'd0 : sc ? 2'd1 : ec ? 2'd2 : 2'd3;
		relevant = ({1'b0, k_q} < used_q);
		if (qry_q.mode == MODE_QUERY) begin
			hit = relevant && (head.chrom == qry_q.chrom_id) && overlap
				&& !(sm == SM_SAME && differ) && !(sm == SM_OPPOSITE && !differ);
		end else begin
			hit = relevant && ((head.cnt != 16'd0) || emit_unfound);
		end
	end

	// Saturating updates of the head entry on a query hit
	always_comb begin
		upd = head;
		add_src = (sm == SM_SPLIT && differ) ? head.ssum : head.psum;
		sum_w = {1'b0, add_src} + {17'd0, qry_q.weight};
		add_res = sum_w[48] ? MAX48 : sum_w[47:0];
		if (hit && qry_q.mode == MODE_QUERY) begin
			upd.cnt = (head.cnt == MAX16) ? head.cnt : head.cnt + 16'd1;
			if (sm == SM_SPLIT && differ) begin
				upd.ssum = add_res;
			end else begin
				upd.psum = add_res;
			end
		end
	end

	assign tail_in = upd;

	// Result built for the head entry
	always_comb begin
		hit_rsp = '0;
		hit_rsp.entry_index     = k_q;
		hit_rsp.found_count     = upd.cnt;
		hit_rsp.sense_total     = upd.psum;
		hit_rsp.antisense_total = upd.ssum;
		if (qry_q.mode == MODE_QUERY) begin
			hit_rsp.kind          = KIND_MATCH;
			hit_rsp.overlap_class = cls;
			hit_rsp.antisense     = (sm != SM_IGNORE) && differ;
			hit_rsp.split_group   = (sm == SM_SPLIT) && differ;
		end else begin
			hit_rsp.kind = KIND_TOTAL;
		end
	end

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_data.mode == MODE_QUERY || req_data.mode == MODE_DUMP) begin
						state_n = ST_SCAN;
					end else if (req_data.mode == MODE_LOAD && used_q >= FULL_CNT) begin
						state_n = ST_FLUSH;
					end
				end
			end
			ST_SCAN: begin
				if (can_push && k_q == LAST_IDX) begin
					state_n = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (can_push) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		req_ready    = 1'b0;
		step         = 1'b0;
		push         = 1'b0;
		push_data    = hold_q;
		ctl.shift    = 1'b0;
		ctl.load     = 1'b0;
		ctl.load_idx = used_q[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				ctl.load  = accept && req_data.mode == MODE_LOAD && used_q < FULL_CNT;
			end
			ST_SCAN: begin
				step      = can_push;
				ctl.shift = can_push;
				push      = can_push && hit && hold_v_q;
				push_data.last = 1'b0;
			end
			ST_FLUSH: begin
				push = can_push;
				if (hold_v_q) begin
					push_data.last = 1'b1;
				end else begin
					push_data      = '0;
					push_data.kind = full_q ? KIND_FULL : KIND_NONE;
					push_data.last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		load_data           = '0;
		load_data.chrom     = req_data.chrom_id;
		load_data.start_pos = req_data.start_pos;
		load_data.end_pos   = req_data.end_pos;
		load_data.strand    = req_data.strand;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			k_q         <= '0;
			full_q      <= 1'b0;
			hold_v_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (accept) begin
				k_q      <= '0;
				hold_v_q <= 1'b0;
				full_q   <= (req_data.mode == MODE_LOAD) && (used_q >= FULL_CNT);
				if (req_data.mode == MODE_CLEAR) begin
					used_q <= '0;
				end else if (req_data.mode == MODE_LOAD && used_q < FULL_CNT) begin
					used_q <= used_q + CNT_W'(1);
				end
			end
			if (step) begin
				k_q <= k_q + IDX_W'(1);
				if (hit) begin
					hold_v_q <= 1'b1;
				end
			end
			if (state_q == ST_FLUSH && can_push) begin
				hold_v_q <= 1'b0;
			end
			if (push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			qry_q <= req_data;
		end
		if (step && hit) begin
			hold_q <= hit_rsp;
		end
		if (push) begin
			rsp_q <= push_data;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= FULL_CNT) else $error("entry count above table size");
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && can_push && k_q == LAST_IDX) |=> (state_q == ST_FLUSH))
		else $error("scan did not end after a full ring turn");
	a_flush_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && can_push) |=> (rsp_valid_q && rsp_q.last))
		else $error("final result missing");

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Testbench for the interval overlap matcher: random and directed requests, scoreboard check.
`timescale 1ns / 1ps
module tb_top;
	import iom_pkg::*;

	localparam int NUM_ENT = 64;
	localparam int CYCLE_LIMIT = 900000;

	// Scoreboard: mirror of the entry table and queue of expected results
	class match_board;
		entry_t    tab [NUM_ENT];
		int        used;
		logic [2:0] smode;
		logic      unfound;
		rsp_t      pending [$];
		int        errors;

		function new();
			used = 0;
			smode = SM_IGNORE;
			unfound = 1'b1;
			errors = 0;
		endfunction

		function logic [47:0] sat48(logic [47:0] a, logic [31:0] b);
			logic [48:0] s;
			s = {1'b0, a} + {17'd0, b};
			return s[48] ? MAX48 : s[47:0];
		endfunction

		function void set_reg(logic idx, logic [2:0] val);
			if (idx == REG_STRAND_MODE)
				smode = val;
			else
				unfound = val[0];
		endfunction

		// Work out the results caused by one accepted request
		function void note_request(req_t q);
			rsp_t r;
			logic [2:0] sm;
			logic differ, sc, ec;
			int n;
			sm = (smode > SM_SPLIT) ? SM_IGNORE : smode;
			n = 0;
			case (q.mode)
				MODE_LOAD: begin
					if (used >= NUM_ENT) begin
						r = '0;
						r.kind = KIND_FULL;
						pending = {pending, r};
						n = 1;
					end else begin
						tab[used] = '{q.chrom_id, q.start_pos, q.end_pos, q.strand, 16'd0,
							48'd0, 48'd0};
						used++;
						return;
					end
				end
				MODE_CLEAR: begin
					used = 0;
					return;
				end
				MODE_QUERY: begin
					for (int i = 0; i < used; i++) begin
						if (tab[i].chrom != q.chrom_id) continue;
						if (tab[i].end_pos < q.start_pos || tab[i].start_pos > q.end_pos) continue;
						differ = tab[i].strand != q.strand;
						if (sm == SM_SAME && differ) continue;
						if (sm == SM_OPPOSITE && !differ) continue;
						sc = q.start_pos >= tab[i].start_pos;
						ec = q.end_pos <= tab[i].end_pos;
						if (tab[i].cnt != MAX16) tab[i].cnt++;
						if (sm == SM_SPLIT && differ)
							tab[i].ssum = sat48(tab[i].ssum, q.weight);
						else
							tab[i].psum = sat48(tab[i].psum, q.weight);
						r = '0;
						r.kind = KIND_MATCH;
						r.entry_index = IDX_W'(i);
						r.overlap_class = (sc && ec) ? 2'd0 : sc ? 2'd1 : ec ? 2'd2 : 2'd3;
						r.antisense = (sm == SM_IGNORE) ? 1'b0 : differ;
						r.split_group = (sm == SM_SPLIT) && differ;
						r.found_count = tab[i].cnt;
						r.sense_total = tab[i].psum;
						r.antisense_total = tab[i].ssum;
						pending = {pending, r};
						n++;
					end
				end
				default: begin
					for (int i = 0; i < used; i++) begin
						if (tab[i].cnt == 0 && !unfound) continue;
						r = '0;
						r.kind = KIND_TOTAL;
						r.entry_index = IDX_W'(i);
						r.found_count = tab[i].cnt;
						r.sense_total = tab[i].psum;
						r.antisense_total = tab[i].ssum;
						pending = {pending, r};
						n++;
					end
				end
			endcase
			if (n == 0) begin
				r = '0;
				r.kind = KIND_NONE;
				pending = {pending, r};
			end
			pending[pending.size() - 1].last = 1'b1;
		endfunction

		// Compare one accepted result with the oldest expectation
		function void check_result(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				report("result with nothing expected");
				return;
			end
			want = pending.pop_front();
			if (got.kind != want.kind) report("kind");
			if (got.entry_index != want.entry_index) report("entry_index");
			if (got.overlap_class != want.overlap_class) report("overlap_class");
			if (got.antisense != want.antisense) report("antisense");
			if (got.split_group != want.split_group) report("split_group");
			if (got.found_count != want.found_count) report("found_count");
			if (got.sense_total != want.sense_total) report("sense_total");
			if (got.antisense_total != want.antisense_total) report("antisense_total");
			if (got.last != want.last) report("last");
		endfunction

		function void report(string what);
			errors++;
			if (errors <= 40)
				$display("ERROR at %0t: wrong %s", $realtime, what);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	match_board board = new();
	bit calm;          // stretch with no idling
	int cycles;

	always #6 clk = ~clk;

	interval_overlap_matcher_top u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// Receiver: random stalls, check every accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				board.check_result(rsp_data);
			rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 19);
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("interval_overlap_matcher_top: mismatch");
			$finish;
		end
	end

	// Send one request, with an optional random gap before it; valid stays
	// high after acceptance until the next gap or drain lowers it
	task automatic send(req_t q);
		while (!calm && $urandom_range(99) < 19) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= q;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		board.note_request(q);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [2:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_reg(idx, val);
	endtask

	function automatic req_t mk(logic [1:0] m, logic [7:0] c, logic [31:0] s, logic [31:0] e,
		logic st, logic [31:0] w);
		req_t q;
		q = '{m, c, s, e, st, w};
		return q;
	endfunction

	// Random request biased to few chromosomes and near coordinates
	function automatic req_t rand_req();
		req_t q;
		int p;
		logic [31:0] base;
		q.weight = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom;
		q.strand = 1'($urandom_range(1));
		q.chrom_id = 8'(($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(2));
		base = ($urandom_range(7) == 0) ? $urandom : $urandom_range(400);
		q.start_pos = base;
		q.end_pos = ($urandom_range(15) == 0) ? $urandom : base + $urandom_range(150);
		p = $urandom_range(99);
		q.mode = (p < 35) ? MODE_LOAD : (p < 88) ? MODE_QUERY : (p < 97) ? MODE_DUMP : MODE_CLEAR;
		return q;
	endfunction

	initial begin
		calm = 1'b0;
		cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty dump/query, loads, all overlap classes, extremes
		send(mk(MODE_DUMP, 8'd0, 0, 0, 1'b0, 0));
		send(mk(MODE_QUERY, 8'd0, 0, 0, 1'b0, 5));
		send(mk(MODE_LOAD, 8'd1, 100, 200, 1'b0, 0));
		send(mk(MODE_LOAD, 8'd1, 150, 300, 1'b1, 0));
		send(mk(MODE_LOAD, 8'd255, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b1, 0));
		send(mk(MODE_LOAD, 8'd1, 400, 50, 1'b0, 0));
		send(mk(MODE_QUERY, 8'd1, 120, 180, 1'b0, 32'hFFFF_FFFF));
		send(mk(MODE_QUERY, 8'd1, 180, 260, 1'b1, 7));
		send(mk(MODE_QUERY, 8'd1, 50, 160, 1'b0, 3));
		send(mk(MODE_QUERY, 8'd1, 0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
		send(mk(MODE_QUERY, 8'd255, 32'hFFFF_FFFF, 0, 1'b0, 1));
		send(mk(MODE_QUERY, 8'd255, 32'hFFFF_FFF8, 32'hFFFF_FFFF, 1'b1, 2));
		send(mk(MODE_DUMP, 8'd0, 0, 0, 1'b0, 0));
		for (int m = 1; m <= 7; m++) begin
			write_reg(REG_STRAND_MODE, m[2:0]);
			send(mk(MODE_QUERY, 8'd1, 160, 190, 1'b1, 32'h8000_0000));
		end
		write_reg(REG_EMIT_UNFOUND, 3'd0);
		send(mk(MODE_LOAD, 8'd9, 1, 2, 1'b0, 0));
		send(mk(MODE_DUMP, 8'd0, 0, 0, 1'b0, 0));
		send(mk(MODE_CLEAR, 8'd0, 0, 0, 1'b0, 0));
		send(mk(MODE_DUMP, 8'd0, 0, 0, 1'b0, 0));

		// Fill the table, then overflow it
		write_reg(REG_EMIT_UNFOUND, 3'd1);
		calm = 1'b1;
		for (int i = 0; i < 66; i++)
			send(mk(MODE_LOAD, 8'd3, i * 10, i * 10 + 25, i[0], 0));
		// Repeat maximum-weight queries that hit the first two entries
		for (int i = 0; i < 6; i++)
			send(mk(MODE_QUERY, 8'd3, 5, 12, 1'b0, 32'hFFFF_FFFF));
		calm = 1'b0;
		send(mk(MODE_DUMP, 8'd0, 0, 0, 1'b0, 0));
		send(mk(MODE_CLEAR, 8'd0, 0, 0, 1'b0, 0));

		// Random phases over several register settings
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_STRAND_MODE, (ph == 7) ? 3'd7 : 3'(ph % 5));
			write_reg(REG_EMIT_UNFOUND, {2'b00, ph[0]});
			calm = (ph == 3);
			for (int k = 0; k < 42; k++) begin
				if (ph == 2 && k == 25) drain();
				send(rand_req());
			end
		end
		calm = 1'b0;
		drain();
		if (board.errors == 0)
			$display("interval_overlap_matcher_top: match");
		else
			$display("interval_overlap_matcher_top: mismatch");
		$finish;
	end
endmodule

[filelist.f]
rtl/iom_pkg.sv
rtl/iom_cell.sv
rtl/iom_ctrl.sv
rtl/interval_overlap_matcher_top.sv
sim/tb_top.sv
